// ----- sv/lorenz_rk4_step_macros.svh -----
// Assertion macros used by the checker file.
`ifndef LORENZ_RK4_STEP_MACROS_SVH
`define LORENZ_RK4_STEP_MACROS_SVH

// Assert an implication on every clock edge outside reset.
`define LRK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lorenz_rk4_step check failed");

// Assert a next-cycle implication outside reset.
`define LRK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lorenz_rk4_step check failed");

`endif

// ----- sv/lrk_pkg.sv -----
// Package: types, constants and helper functions of the Lorenz RK4 stepper.
`timescale 1ns / 1ps
package lrk_pkg;
	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS = 20;
	localparam int COEF_WIDTH = 31;
	localparam int STEP_WIDTH = 21;
	localparam int CFG_IDX_WIDTH = 2;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_SIGMA = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_RHO = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_BETA = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_STEP = 2'd3;

	localparam logic [COEF_WIDTH-1:0] SIGMA_RESET = 31'd10485760;
	localparam logic [COEF_WIDTH-1:0] RHO_RESET = 31'd29360128;
	localparam logic [COEF_WIDTH-1:0] BETA_RESET = 31'd2796203;
	localparam logic [STEP_WIDTH-1:0] STEP_RESET = 21'd10486;

	localparam logic signed [31:0] WMAX = 32'sh7fffffff;
	localparam logic signed [31:0] WMIN = 32'sh80000000;

	typedef struct packed {
		logic func;
		logic signed [31:0] init_t;
		logic signed [31:0] init_x;
		logic signed [31:0] init_y;
		logic signed [31:0] init_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_t;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic overflow;
	} out_item_t;

	// Datapath operations issued by the sequencer.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,       // load state from input
		OP_EVAL_BASE,  // eval point = state
		OP_D_YX,       // t0 = y - x
		OP_M_SIG,      // t0 = sigma * t0 -> kx
		OP_D_RZ,       // t0 = rho - z
		OP_M_XT,       // t0 = x * t0
		OP_S_TY,       // ky = t0 - y
		OP_M_XY,       // t0 = x * y
		OP_M_BZ,       // t1 = beta * z
		OP_S_KZ,       // kz = t0 - t1
		OP_ACC,        // fold k into slope sums with weight
		OP_M_HKX,      // t0 = h*kx (half or full)
		OP_M_HKY,
		OP_M_HKZ,
		OP_P_X,        // eval x = x + t0
		OP_P_Y,
		OP_P_Z,
		OP_M_HSX,      // t0 = h * sum_x
		OP_M_HSY,
		OP_M_HSZ,
		OP_UPD_X,      // x += t0 / 6
		OP_UPD_Y,
		OP_UPD_Z,
		OP_UPD_T       // t += h
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [1:0] stage;   // RK stage 0..3
		logic clr_ovf;
	} dp_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} ctl_state_t;

	// Saturate a 34-bit signed value to the word, reporting overflow.
	function automatic logic [32:0] sat34(input logic signed [33:0] v);
		logic [32:0] r;
		if (v > 34'sh07fffffff) r = {1'b1, WMAX};
		else if (v < -34'sh080000000) r = {1'b1, WMIN};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction
endpackage

// ----- sv/lrk_ctrl.sv -----
// Sequencer: walks the RK4 operation schedule, at most one datapath operation per cycle.
`timescale 1ns / 1ps
module lrk_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_func,
	input logic out_taken,
	output logic in_stall,
	output logic out_valid,
	output lrk_pkg::dp_cmd_t cmd
);
	lrk_pkg::ctl_state_t state_q, state_d;
	logic [4:0] pc_q, pc_d;
	logic [1:0] stage_q, stage_d;

	// One RK stage: 8 slope ops, accumulate, then next-point ops (state update ops in the last stage).
	localparam logic [4:0] PC_LAST = 5'd19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrk_pkg::ST_IDLE;
			pc_q <= '0;
			stage_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			stage_q <= stage_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		stage_d = stage_q;
		cmd = '{op: lrk_pkg::OP_NOP, stage: stage_q, clr_ovf: 1'b0};
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			lrk_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.clr_ovf = 1'b1;
					pc_d = '0;
					stage_d = '0;
					if (!in_func) begin
						cmd.op = lrk_pkg::OP_LOAD;
						state_d = lrk_pkg::ST_OUT;
					end else begin
						cmd.op = lrk_pkg::OP_EVAL_BASE;
						state_d = lrk_pkg::ST_RUN;
					end
				end
			end
			lrk_pkg::ST_RUN: begin
				pc_d = pc_q + 5'd1;
				unique case (pc_q)
					5'd0: cmd.op = lrk_pkg::OP_D_YX;
					5'd1: cmd.op = lrk_pkg::OP_M_SIG;
					5'd2: cmd.op = lrk_pkg::OP_D_RZ;
					5'd3: cmd.op = lrk_pkg::OP_M_XT;
					5'd4: cmd.op = lrk_pkg::OP_S_TY;
					5'd5: cmd.op = lrk_pkg::OP_M_XY;
					5'd6: cmd.op = lrk_pkg::OP_M_BZ;
					5'd7: cmd.op = lrk_pkg::OP_S_KZ;
					5'd8: cmd.op = lrk_pkg::OP_ACC;
					5'd9: cmd.op = (stage_q == 2'd3) ? lrk_pkg::OP_M_HSX : lrk_pkg::OP_M_HKX;
					5'd10: cmd.op = (stage_q == 2'd3) ? lrk_pkg::OP_UPD_X : lrk_pkg::OP_P_X;
					5'd11: cmd.op = (stage_q == 2'd3) ? lrk_pkg::OP_M_HSY : lrk_pkg::OP_M_HKY;
					5'd12: cmd.op = (stage_q == 2'd3) ? lrk_pkg::OP_UPD_Y : lrk_pkg::OP_P_Y;
					5'd13: cmd.op = (stage_q == 2'd3) ? lrk_pkg::OP_M_HSZ : lrk_pkg::OP_M_HKZ;
					5'd14: cmd.op = (stage_q == 2'd3) ? lrk_pkg::OP_UPD_Z : lrk_pkg::OP_P_Z;
					5'd15: begin
						if (stage_q == 2'd3) begin
							cmd.op = lrk_pkg::OP_UPD_T;
							pc_d = PC_LAST;
						end else begin
							pc_d = '0;
							stage_d = stage_q + 2'd1;
						end
					end
					default: begin
						state_d = lrk_pkg::ST_OUT;
					end
				endcase
			end
			lrk_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_taken) state_d = lrk_pkg::ST_IDLE;
			end
			default: state_d = lrk_pkg::ST_IDLE;
		endcase
	end
endmodule

// ----- sv/lrk_dp.sv -----
// Datapath: state, coefficients, slope registers and a shared fixed-point multiplier.
`timescale 1ns / 1ps
module lrk_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lrk_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input logic [lrk_pkg::COEF_WIDTH-1:0] cfg_data,
	input lrk_pkg::in_item_t in_item,
	input lrk_pkg::dp_cmd_t cmd,
	output lrk_pkg::out_item_t out_item
);
	logic [lrk_pkg::COEF_WIDTH-1:0] sigma_q, rho_q, beta_q;
	logic [lrk_pkg::STEP_WIDTH-1:0] step_q;
	logic signed [31:0] t_q, x_q, y_q, z_q;
	logic signed [31:0] ex_q, ey_q, ez_q;       // evaluation point
	logic signed [31:0] kx_q, ky_q, kz_q;       // current slopes
	logic signed [31:0] sx_q, sy_q, sz_q;       // weighted slope sums
	logic signed [31:0] t0_q, t1_q;
	logic ovf_q;

	// Multiplier operand select.
	logic signed [31:0] ma, mb;
	logic extra;
	always_comb begin
		ma = t0_q;
		mb = t0_q;
		extra = 1'b0;
		unique case (cmd.op)
			lrk_pkg::OP_M_SIG: begin ma = $signed({1'b0, sigma_q}); mb = t0_q; end
			lrk_pkg::OP_M_XT: begin ma = ex_q; mb = t0_q; end
			lrk_pkg::OP_M_XY: begin ma = ex_q; mb = ey_q; end
			lrk_pkg::OP_M_BZ: begin ma = $signed({1'b0, beta_q}); mb = ez_q; end
			lrk_pkg::OP_M_HKX: begin ma = $signed({11'd0, step_q}); mb = kx_q; end
			lrk_pkg::OP_M_HKY: begin ma = $signed({11'd0, step_q}); mb = ky_q; end
			lrk_pkg::OP_M_HKZ: begin ma = $signed({11'd0, step_q}); mb = kz_q; end
			lrk_pkg::OP_M_HSX: begin ma = $signed({11'd0, step_q}); mb = sx_q; end
			lrk_pkg::OP_M_HSY: begin ma = $signed({11'd0, step_q}); mb = sy_q; end
			lrk_pkg::OP_M_HSZ: begin ma = $signed({11'd0, step_q}); mb = sz_q; end
			default: begin ma = t0_q; mb = t0_q; end
		endcase
		if ((cmd.op == lrk_pkg::OP_M_HKX || cmd.op == lrk_pkg::OP_M_HKY ||
				cmd.op == lrk_pkg::OP_M_HKZ) && cmd.stage != 2'd2)
			extra = 1'b1;
	end

	// Magnitude product, round half away from zero, saturate.
	logic neg;
	logic [31:0] ua, ub;
	logic [63:0] prod, biased, q;
	logic [32:0] mres;
	always_comb begin
		neg = ma[31] ^ mb[31];
		ua = ma[31] ? 32'(-ma) : 32'(ma);
		ub = mb[31] ? 32'(-mb) : 32'(mb);
		prod = ua * ub;
		biased = prod + (extra ? 64'h100000 : 64'h80000);
		q = extra ? (biased >> 21) : (biased >> 20);
		if (ua == 32'd0 || ub == 32'd0) mres = '0;
		else if (neg) begin
			if (q > 64'h80000000) mres = {1'b1, lrk_pkg::WMIN};
			else mres = {1'b0, 32'(-q)};
		end else begin
			if (q > 64'h7fffffff) mres = {1'b1, lrk_pkg::WMAX};
			else mres = {1'b0, q[31:0]};
		end
	end

	// Divide h*sum by 6 with rounding, on the magnitude, by reciprocal multiply.
	logic [31:0] pm;
	logic [31:0] pm3;
	logic [63:0] recip;
	logic [31:0] d6;
	logic signed [31:0] inc6;
	always_comb begin
		pm = t0_q[31] ? 32'(-t0_q) : 32'(t0_q);
		pm3 = pm + 32'd3;
		recip = {32'd0, pm3} * 64'h00000000aaaaaaab;
		d6 = {2'b00, recip[63:34]};
		inc6 = t0_q[31] ? -$signed(d6) : $signed(d6);
	end

	// Shared saturating adder.
	logic signed [31:0] aa, ab;
	logic sub;
	logic [32:0] ares;
	always_comb begin
		aa = t0_q;
		ab = t1_q;
		sub = 1'b0;
		unique case (cmd.op)
			lrk_pkg::OP_D_YX: begin aa = ey_q; ab = ex_q; sub = 1'b1; end
			lrk_pkg::OP_D_RZ: begin aa = $signed({1'b0, rho_q}); ab = ez_q; sub = 1'b1; end
			lrk_pkg::OP_S_TY: begin aa = t0_q; ab = ey_q; sub = 1'b1; end
			lrk_pkg::OP_S_KZ: begin aa = t0_q; ab = t1_q; sub = 1'b1; end
			lrk_pkg::OP_P_X: begin aa = x_q; ab = t0_q; end
			lrk_pkg::OP_P_Y: begin aa = y_q; ab = t0_q; end
			lrk_pkg::OP_P_Z: begin aa = z_q; ab = t0_q; end
			lrk_pkg::OP_UPD_X: begin aa = x_q; ab = inc6; end
			lrk_pkg::OP_UPD_Y: begin aa = y_q; ab = inc6; end
			lrk_pkg::OP_UPD_Z: begin aa = z_q; ab = inc6; end
			lrk_pkg::OP_UPD_T: begin aa = t_q; ab = $signed({11'd0, step_q}); end
			default: begin aa = t0_q; ab = t1_q; end
		endcase
		ares = lrk_pkg::sat34(sub ? (34'(aa) - 34'(ab)) : (34'(aa) + 34'(ab)));
	end

	// Slope folding: middle stages count twice, each add saturated in order.
	logic [32:0] ax1, ax2, ay1, ay2, az1, az2;
	logic ovf_acc;
	always_comb begin
		ax1 = lrk_pkg::sat34(34'(kx_q) + 34'(kx_q));
		ay1 = lrk_pkg::sat34(34'(ky_q) + 34'(ky_q));
		az1 = lrk_pkg::sat34(34'(kz_q) + 34'(kz_q));
		if (cmd.stage == 2'd1 || cmd.stage == 2'd2) begin
			ax2 = lrk_pkg::sat34(34'(sx_q) + 34'($signed(ax1[31:0])));
			ay2 = lrk_pkg::sat34(34'(sy_q) + 34'($signed(ay1[31:0])));
			az2 = lrk_pkg::sat34(34'(sz_q) + 34'($signed(az1[31:0])));
			ovf_acc = ax1[32] | ay1[32] | az1[32] | ax2[32] | ay2[32] | az2[32];
		end else if (cmd.stage == 2'd3) begin
			ax2 = lrk_pkg::sat34(34'(sx_q) + 34'(kx_q));
			ay2 = lrk_pkg::sat34(34'(sy_q) + 34'(ky_q));
			az2 = lrk_pkg::sat34(34'(sz_q) + 34'(kz_q));
			ovf_acc = ax2[32] | ay2[32] | az2[32];
		end else begin
			ax2 = {1'b0, kx_q};
			ay2 = {1'b0, ky_q};
			az2 = {1'b0, kz_q};
			ovf_acc = 1'b0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= lrk_pkg::SIGMA_RESET;
			rho_q <= lrk_pkg::RHO_RESET;
			beta_q <= lrk_pkg::BETA_RESET;
			step_q <= lrk_pkg::STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrk_pkg::REG_SIGMA: sigma_q <= cfg_data;
				lrk_pkg::REG_RHO: rho_q <= cfg_data;
				lrk_pkg::REG_BETA: beta_q <= cfg_data;
				lrk_pkg::REG_STEP: step_q <= cfg_data[lrk_pkg::STEP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Architectural state and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.clr_ovf) ovf_q <= 1'b0;
			unique case (cmd.op)
				lrk_pkg::OP_LOAD: begin
					t_q <= in_item.init_t;
					x_q <= in_item.init_x;
					y_q <= in_item.init_y;
					z_q <= in_item.init_z;
				end
				lrk_pkg::OP_UPD_X: begin x_q <= ares[31:0]; ovf_q <= ovf_q | ares[32]; end
				lrk_pkg::OP_UPD_Y: begin y_q <= ares[31:0]; ovf_q <= ovf_q | ares[32]; end
				lrk_pkg::OP_UPD_Z: begin z_q <= ares[31:0]; ovf_q <= ovf_q | ares[32]; end
				lrk_pkg::OP_UPD_T: begin t_q <= ares[31:0]; ovf_q <= ovf_q | ares[32]; end
				lrk_pkg::OP_D_YX, lrk_pkg::OP_D_RZ, lrk_pkg::OP_S_TY, lrk_pkg::OP_S_KZ,
				lrk_pkg::OP_P_X, lrk_pkg::OP_P_Y, lrk_pkg::OP_P_Z:
					ovf_q <= ovf_q | ares[32];
				lrk_pkg::OP_M_SIG, lrk_pkg::OP_M_XT, lrk_pkg::OP_M_XY, lrk_pkg::OP_M_BZ,
				lrk_pkg::OP_M_HKX, lrk_pkg::OP_M_HKY, lrk_pkg::OP_M_HKZ,
				lrk_pkg::OP_M_HSX, lrk_pkg::OP_M_HSY, lrk_pkg::OP_M_HSZ:
					ovf_q <= ovf_q | mres[32];
				lrk_pkg::OP_ACC: ovf_q <= ovf_q | ovf_acc;
				default: ;
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lrk_pkg::OP_EVAL_BASE: begin ex_q <= x_q; ey_q <= y_q; ez_q <= z_q; end
			lrk_pkg::OP_D_YX, lrk_pkg::OP_D_RZ: t0_q <= ares[31:0];
			lrk_pkg::OP_M_SIG: kx_q <= mres[31:0];
			lrk_pkg::OP_M_XT, lrk_pkg::OP_M_XY: t0_q <= mres[31:0];
			lrk_pkg::OP_S_TY: ky_q <= ares[31:0];
			lrk_pkg::OP_M_BZ: t1_q <= mres[31:0];
			lrk_pkg::OP_S_KZ: kz_q <= ares[31:0];
			lrk_pkg::OP_ACC: begin
				sx_q <= ax2[31:0];
				sy_q <= ay2[31:0];
				sz_q <= az2[31:0];
			end
			lrk_pkg::OP_M_HKX, lrk_pkg::OP_M_HKY, lrk_pkg::OP_M_HKZ,
			lrk_pkg::OP_M_HSX, lrk_pkg::OP_M_HSY, lrk_pkg::OP_M_HSZ:
				t0_q <= mres[31:0];
			lrk_pkg::OP_P_X: ex_q <= ares[31:0];
			lrk_pkg::OP_P_Y: ey_q <= ares[31:0];
			lrk_pkg::OP_P_Z: ez_q <= ares[31:0];
			default: ;
		endcase
	end

	assign out_item = '{out_t: t_q, out_x: x_q, out_y: y_q, out_z: z_q, overflow: ovf_q};
endmodule

// ----- sv/lorenz_rk4_step.sv -----
// Top level of the Lorenz RK4 stepper: sequencer plus datapath.
// Usage:
//   Input channel (in_valid/in_stall, in_data) carries one transaction per item.
//   func=0 loads t, x, y, z and returns them; func=1 runs one RK4 step.
//   Output channel (out_valid/out_stall, out_data) returns one transaction
//   per item with the new state and an overflow flag.
//   A load shows its result in the cycle after acceptance; a step shows it
//   after walking 4 stages in the sequencer and a closing step, set by the
//   shared multiplier and adder walked in order.
//   The next item is taken in the cycle after the result leaves.
//   One item is in work at a time; in_stall stays high until the result leaves.
//   If the receiver stalls, the result holds on out_data until taken.
//   Reset clears the state to zero and loads default coefficients
//   (sigma 10, rho 28, beta 8/3 in Q11.20, h 0.01 in Q1.20).
//   Configuration writes (cfg_we, cfg_index, cfg_data) are the user's to make
//   only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module lorenz_rk4_step (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lrk_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lrk_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [lrk_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input logic [lrk_pkg::COEF_WIDTH-1:0] cfg_data
);
	lrk_pkg::dp_cmd_t cmd;

	lrk_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_func(in_data.func),
		.out_taken(!out_stall),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.cmd(cmd)
	);

	lrk_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_item(in_data),
		.cmd(cmd),
		.out_item(out_data)
	);
endmodule

// ----- sv/lrk_checker.sv -----
// Port-level checker for the Lorenz RK4 stepper, bound to the top level.
`timescale 1ns / 1ps
`include "lorenz_rk4_step_macros.svh"
module lrk_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input lrk_pkg::out_item_t out_data
);
	`LRK_ASSERT_IMP(a_no_accept_while_out, clk, arst_n, out_valid, in_stall)
	`LRK_ASSERT_NXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`LRK_ASSERT_NXT(a_load_result, clk, arst_n, in_valid && !in_stall, !out_valid || in_stall)
endmodule

bind lorenz_rk4_step lrk_checker u_lrk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
